// ===== hdl/consistent_hash_ring_replica_lookup_unit_macros.svh =====
// ============================================================================
// Consistent hash ring lookup unit assertion macros
// Shared clocked assertion forms used by the top level.
// ============================================================================
`ifndef CONSISTENT_HASH_RING_REPLICA_LOOKUP_UNIT_MACROS_SVH
`define CONSISTENT_HASH_RING_REPLICA_LOOKUP_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHRL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHRL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/chrl_pkg.sv =====
// ============================================================================
// Consistent hash ring lookup package
// Types, sizes and constants shared by the ring lookup modules.
// ============================================================================
package chrl_pkg;

    localparam int RING_SIZE    = 1024;
    localparam int NODE_COUNT   = 64;
    localparam int MAX_REPLICAS = 8;
    localparam int OUT_LIMIT    = 8;
    localparam int WANT_MAX     = (MAX_REPLICAS < OUT_LIMIT) ? MAX_REPLICAS : OUT_LIMIT;

    localparam int AW = $clog2(RING_SIZE);
    localparam int CW = $clog2(RING_SIZE + 1);
    localparam int NW = $clog2(NODE_COUNT);

    localparam logic [63:0] FNV_BASIS    = 64'hCBF29CE484222325;
    // The FNV prime is 2^40 + 0x1B3.
    localparam int          FNV_SHIFT    = 40;
    localparam logic [63:0] FNV_PRIME_LO = 64'h00000000000001B3;

    localparam logic [1:0] MODE_KEY    = 2'd0;
    localparam logic [1:0] MODE_INSERT = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic KIND_REPLICA = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        CMD_LOOKUP,
        CMD_INSERT,
        CMD_CLEAR
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t     op;
        logic [63:0] value;
        logic [5:0]  node;
    } cmd_t;

    typedef struct packed {
        logic        kind;
        logic [5:0]  node;
        logic [2:0]  rank;
        logic        found;
        logic [63:0] stored;
        logic        full;
        logic        last;
    } res_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_INS_RD,
        ST_INS_CHK,
        ST_SH_RD,
        ST_SH_WR,
        ST_INS_PUT,
        ST_ACK,
        ST_EMPTY,
        ST_LK_RD,
        ST_LK_CHK,
        ST_LK_FIN
    } back_state_t;

endpackage

// ===== hdl/chrl_cmd_fifo.sv =====
// ============================================================================
// Command queue
// Small register FIFO between the front classifier and the ring engine.
// ============================================================================
module chrl_cmd_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  chrl_pkg::cmd_t        push_cmd,
    input  logic                  pop,
    output chrl_pkg::cmd_t        head,
    output chrl_pkg::fifo_status_t status
);
    import chrl_pkg::*;

    cmd_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign status.full  = (cnt_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hdl/chrl_front.sv =====
// ============================================================================
// Front classifier
// Folds key bytes into the FNV-1a hash and queues lookup, insert and clear
// commands for the ring engine.
// ============================================================================
module chrl_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [1:0]             mode,
    input  logic [7:0]             key_byte,
    input  logic                   key_last,
    input  logic [63:0]            token_value,
    input  logic [5:0]             node_index,
    input  chrl_pkg::fifo_status_t q_status,
    output logic                   q_push,
    output chrl_pkg::cmd_t         q_cmd
);
    import chrl_pkg::*;

    logic [63:0] hash_reg, hash_next;
    logic [63:0] mixed;
    logic [63:0] product;
    logic        accept;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign mixed    = hash_reg ^ {56'd0, key_byte};
    // Multiply by the prime as a shift plus a narrow constant product.
    assign product  = (mixed << FNV_SHIFT) + 64'(mixed * FNV_PRIME_LO);

    always_comb
    begin
        hash_next  = hash_reg;
        q_push     = 1'b0;
        q_cmd.op   = CMD_LOOKUP;
        q_cmd.value = product;
        q_cmd.node = node_index;
        if (accept)
        begin
            case (mode)
                MODE_KEY:
                begin
                    if (key_last)
                    begin
                        q_push    = 1'b1;
                        hash_next = FNV_BASIS;
                    end
                    else
                    begin
                        hash_next = product;
                    end
                end
                MODE_INSERT:
                begin
                    q_push      = 1'b1;
                    q_cmd.op    = CMD_INSERT;
                    q_cmd.value = token_value;
                end
                MODE_CLEAR:
                begin
                    q_push   = 1'b1;
                    q_cmd.op = CMD_CLEAR;
                end
                default:
                begin
                    q_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= FNV_BASIS;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

endmodule

// ===== hdl/chrl_back.sv =====
// ============================================================================
// Ring engine
// Holds the sorted token store, runs binary searches, inserts with shifting
// and walks the ring for distinct replica owners.
// ============================================================================
module chrl_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [3:0]             rf_value,
    input  chrl_pkg::fifo_status_t q_status,
    input  chrl_pkg::cmd_t         q_head,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output chrl_pkg::res_t         out_res
);
    import chrl_pkg::*;

    logic [63:0]   mem_val [RING_SIZE];
    logic [NW-1:0] mem_own [RING_SIZE];

    back_state_t   state_reg, state_next;
    cmd_op_t       op_reg, op_next;
    logic [CW-1:0] lo_reg, lo_next, hi_reg, hi_next;
    logic [AW-1:0] mid_reg, mid_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [AW-1:0] idx_reg, idx_next, start_reg, start_next;
    logic [63:0]   value_reg, value_next;
    logic [NW-1:0] node_reg, node_next;
    logic [CW-1:0] count_reg, count_next;
    logic [NODE_COUNT-1:0] chosen_reg, chosen_next;
    logic [3:0]    n_reg, n_next, want_reg, want_next;
    logic          full_reg, full_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [NW-1:0] pend_node_reg, pend_node_next;
    logic [2:0]    pend_rank_reg, pend_rank_next;
    logic          out_valid_reg, out_valid_next;
    res_t          out_res_reg, out_res_next;

    logic [AW-1:0] rd_addr;
    logic [63:0]   rd_val_reg;
    logic [NW-1:0] rd_own_reg;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [63:0]   wr_val;
    logic [NW-1:0] wr_own;

    logic          out_free;
    logic          load;
    res_t          load_res;
    logic [CW-1:0] mid_full;
    logic [CW-1:0] idx_inc;
    logic [AW-1:0] idx_wrap;
    logic          is_new;
    logic [3:0]    n_after;
    logic          walk_done;
    logic [63:0]   value_inc;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    assign mid_full  = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign idx_inc   = {1'b0, idx_reg} + 1'b1;
    assign idx_wrap  = (idx_inc == count_reg) ? '0 : idx_inc[AW-1:0];
    assign is_new    = !chosen_reg[rd_own_reg];
    assign n_after   = n_reg + {3'd0, is_new};
    assign walk_done = (n_after >= want_reg) || (idx_wrap == start_reg);
    assign value_inc = value_reg + 64'd1;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    case (q_head.op)
                        CMD_INSERT:
                            state_next = (count_reg == CW'(RING_SIZE)) ? ST_ACK : ST_SRCH_RD;
                        CMD_LOOKUP:
                            state_next = (count_reg == '0) ? ST_EMPTY : ST_SRCH_RD;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SRCH_RD:
            begin
                if (lo_reg < hi_reg)
                    state_next = ST_SRCH_CMP;
                else if (op_reg == CMD_INSERT)
                    state_next = ST_INS_RD;
                else
                    state_next = ST_LK_RD;
            end
            ST_SRCH_CMP: state_next = ST_SRCH_RD;
            ST_INS_RD:   state_next = (pos_reg < count_reg) ? ST_INS_CHK : ST_SH_RD;
            ST_INS_CHK:  state_next = (rd_val_reg == value_reg) ? ST_INS_RD : ST_SH_RD;
            ST_SH_RD:    state_next = ({1'b0, idx_reg} > pos_reg) ? ST_SH_WR : ST_INS_PUT;
            ST_SH_WR:    state_next = ST_SH_RD;
            ST_INS_PUT:  state_next = ST_ACK;
            ST_ACK:      state_next = out_free ? ST_IDLE : ST_ACK;
            ST_EMPTY:    state_next = out_free ? ST_IDLE : ST_EMPTY;
            ST_LK_RD:    state_next = ST_LK_CHK;
            ST_LK_CHK:
            begin
                if (!(is_new && pend_valid_reg && !out_free))
                    state_next = walk_done ? ST_LK_FIN : ST_LK_RD;
            end
            ST_LK_FIN:   state_next = out_free ? ST_IDLE : ST_LK_FIN;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        op_next         = op_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        start_next      = start_reg;
        value_next      = value_reg;
        node_next       = node_reg;
        count_next      = count_reg;
        chosen_next     = chosen_reg;
        n_next          = n_reg;
        want_next       = want_reg;
        full_next       = full_reg;
        pend_valid_next = pend_valid_reg;
        pend_node_next  = pend_node_reg;
        pend_rank_next  = pend_rank_reg;
        q_pop           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_val          = rd_val_reg;
        wr_own          = rd_own_reg;
        load            = 1'b0;
        load_res        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_pop      = 1'b1;
                    op_next    = q_head.op;
                    value_next = q_head.value;
                    node_next  = q_head.node[NW-1:0];
                    lo_next    = '0;
                    hi_next    = count_reg;
                    full_next  = 1'b1;
                    chosen_next     = '0;
                    n_next          = '0;
                    pend_valid_next = 1'b0;
                    if (rf_value == 4'd0)
                        want_next = 4'd1;
                    else if (rf_value > 4'(WANT_MAX))
                        want_next = 4'(WANT_MAX);
                    else
                        want_next = rf_value;
                    if (q_head.op == CMD_CLEAR)
                        count_next = '0;
                end
            end
            ST_SRCH_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_addr  = mid_full[AW-1:0];
                    mid_next = mid_full[AW-1:0];
                end
                else
                begin
                    pos_next   = lo_reg;
                    start_next = (lo_reg >= count_reg) ? '0 : lo_reg[AW-1:0];
                    idx_next   = (lo_reg >= count_reg) ? '0 : lo_reg[AW-1:0];
                end
            end
            ST_SRCH_CMP:
            begin
                if (rd_val_reg < value_reg)
                    lo_next = {1'b0, mid_reg} + 1'b1;
                else
                    hi_next = {1'b0, mid_reg};
            end
            ST_INS_RD:
            begin
                rd_addr  = pos_reg[AW-1:0];
                idx_next = count_reg[AW-1:0];
            end
            ST_INS_CHK:
            begin
                if (rd_val_reg == value_reg)
                begin
                    // A taken value is bumped; the next candidate slot follows,
                    // or the ring start when the value wraps to zero.
                    value_next = value_inc;
                    pos_next   = (value_inc == '0) ? '0 : pos_reg + 1'b1;
                end
            end
            ST_SH_RD:
            begin
                rd_addr = idx_reg - 1'b1;
            end
            ST_SH_WR:
            begin
                wr_en    = 1'b1;
                wr_addr  = idx_reg;
                idx_next = idx_reg - 1'b1;
            end
            ST_INS_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg[AW-1:0];
                wr_val     = value_reg;
                wr_own     = node_reg;
                count_next = count_reg + 1'b1;
                full_next  = 1'b0;
            end
            ST_ACK:
            begin
                if (out_free)
                begin
                    load            = 1'b1;
                    load_res.kind   = KIND_ACK;
                    load_res.stored = full_reg ? '0 : value_reg;
                    load_res.full   = full_reg;
                    load_res.last   = 1'b1;
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    load          = 1'b1;
                    load_res.kind = KIND_REPLICA;
                    load_res.last = 1'b1;
                end
            end
            ST_LK_RD:
            begin
                rd_addr = idx_reg;
            end
            ST_LK_CHK:
            begin
                rd_addr = idx_reg;
                if (!(is_new && pend_valid_reg && !out_free))
                begin
                    // The newest owner is held back so the final one can carry last.
                    if (is_new)
                    begin
                        chosen_next[rd_own_reg] = 1'b1;
                        if (pend_valid_reg)
                        begin
                            load           = 1'b1;
                            load_res.kind  = KIND_REPLICA;
                            load_res.node  = 6'(pend_node_reg);
                            load_res.rank  = pend_rank_reg;
                            load_res.found = 1'b1;
                        end
                        pend_valid_next = 1'b1;
                        pend_node_next  = rd_own_reg;
                        pend_rank_next  = n_reg[2:0];
                    end
                    n_next   = n_after;
                    idx_next = idx_wrap;
                end
            end
            ST_LK_FIN:
            begin
                if (out_free)
                begin
                    load           = 1'b1;
                    load_res.kind  = KIND_REPLICA;
                    load_res.node  = 6'(pend_node_reg);
                    load_res.rank  = pend_rank_reg;
                    load_res.found = 1'b1;
                    load_res.last  = 1'b1;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase

        out_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        out_res_next   = load ? load_res : out_res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            chosen_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            chosen_reg     <= chosen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        pos_reg       <= pos_next;
        idx_reg       <= idx_next;
        start_reg     <= start_next;
        value_reg     <= value_next;
        node_reg      <= node_next;
        n_reg         <= n_next;
        want_reg      <= want_next;
        full_reg      <= full_next;
        pend_node_reg <= pend_node_next;
        pend_rank_reg <= pend_rank_next;
        out_res_reg   <= out_res_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_val[wr_addr] <= wr_val;
            mem_own[wr_addr] <= wr_own;
        end
        rd_val_reg <= mem_val[rd_addr];
        rd_own_reg <= mem_own[rd_addr];
    end

endmodule

// ===== hdl/consistent_hash_ring_replica_lookup_unit.sv =====
// Key bytes are accepted one per cycle while the four-word command queue has room.
// The engine runs one command at a time: a binary search over the stored tokens, then
// a lookup walks the ring entry by entry to the final replica; an insert steps past
// each taken slot, shifts the entries above its position up and writes the token.
// Full-ring inserts and empty-ring lookups skip the search and answer directly.
// Reset is asynchronous, active low: ring empty, hash at the FNV basis, factor 1.
module consistent_hash_ring_replica_lookup_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // key_byte[7:0], token_value[71:8], node_index[77:72], zero pad
    input  logic [79:0] s_tdata,
    // mode[1:0]
    input  logic [1:0]  s_tuser,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // replica_node[5:0], rank[8:6], found[9], stored_value[73:10],
    // ring_full[74], zero pad
    output logic [79:0] m_tdata,
    // kind[0]
    output logic [0:0]  m_tuser,
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);
    import chrl_pkg::*;

    `include "consistent_hash_ring_replica_lookup_unit_macros.svh"

    logic [3:0]   rf_reg;
    fifo_status_t q_status;
    logic         q_push, q_pop;
    cmd_t         q_cmd, q_head;
    res_t         res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_reg <= 4'd1;
        end
        else if (cfg_valid)
        begin
            rf_reg <= cfg_data;
        end
    end

    chrl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .mode        (s_tuser),
        .key_byte    (s_tdata[7:0]),
        .key_last    (s_tlast),
        .token_value (s_tdata[71:8]),
        .node_index  (s_tdata[77:72]),
        .q_status    (q_status),
        .q_push      (q_push),
        .q_cmd       (q_cmd)
    );

    chrl_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head     (q_head),
        .status   (q_status)
    );

    chrl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rf_value  (rf_reg),
        .q_status  (q_status),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {5'd0, res.full, res.stored, res.found, res.rank, res.node};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

    `CHRL_ASSERT_IMP(a_ack_last, m_tvalid && (m_tuser == KIND_ACK), m_tlast, "ack not last")
    `CHRL_ASSERT_IMP(a_full_zero, m_tvalid && m_tdata[74], m_tdata[73:10] == 64'd0, "full ack has value")
    `CHRL_ASSERT_IMP(a_notfound_last, m_tvalid && (m_tuser == KIND_REPLICA) && !m_tdata[9], m_tlast && (m_tdata[8:6] == 3'd0), "empty result malformed")
    `CHRL_ASSERT_IMP(a_q_stall, q_status.full, !s_tready, "front ready with full queue")
    `CHRL_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "word dropped")

endmodule

// ===== dv/testbench.sv =====
// ============================================================================
// Ring lookup unit testbench
// Drives key bytes, token inserts and clears into the ring lookup unit with
// random idling on both streams. It predicts every replica result and insert
// acknowledgement, and compares each result word field by field.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import chrl_pkg::*;

    localparam int WATCHDOG_LIMIT = 100000;
    localparam int SETTLE_CYCLES  = 400;
    localparam int REFILL_COUNT   = 8;
    localparam int PHASE_WORDS    = 26;
    // Mode three carries no command and is dropped by the block.
    localparam logic [1:0] MODE_RESERVED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [3:0]  cfg_data;

    consistent_hash_ring_replica_lookup_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // Predicted ring contents, kept sorted like the block's store.
    logic [63:0] ring_val [RING_SIZE];
    logic [5:0]  ring_own [RING_SIZE];
    int          ring_cnt;
    logic [63:0] hash_acc;
    logic [3:0]  repl_factor;
    res_t        expected_results[$];
    int          errors;
    bit          no_idle;
    int          idle_cycles;
    int          stall_left;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Result stream back-pressure: mostly ready, some short drops, a few long stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (no_idle)
        begin
            m_tready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            int r;
            r = $urandom_range(0, 99);
            if (r < 4)
                stall_left <= $urandom_range(10, 40);
            m_tready <= (r >= 25);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic void check_field(string name, logic [63:0] exp_v,
                                        logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            res_t want;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result word: %h kind %0d", m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("kind", want.kind, m_tuser[0]);
                check_field("replica_node", want.node, m_tdata[5:0]);
                check_field("rank", want.rank, m_tdata[8:6]);
                check_field("found", want.found, m_tdata[9]);
                check_field("stored_value", want.stored, m_tdata[73:10]);
                check_field("ring_full", want.full, m_tdata[74]);
                check_field("last", want.last, m_tlast);
            end
        end
    end

    function automatic void queue_result(res_t r);
        expected_results = {expected_results, r};
    endfunction

    function automatic int lower_index(logic [63:0] v);
        int lo, hi, mid;
        lo = 0;
        hi = ring_cnt;
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (ring_val[mid] < v)
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic res_t make_res(logic kind, logic [5:0] node, logic [2:0] rank,
                                      logic found, logic [63:0] stored, logic full,
                                      logic last);
        res_t r;
        r.kind   = kind;
        r.node   = node;
        r.rank   = rank;
        r.found  = found;
        r.stored = stored;
        r.full   = full;
        r.last   = last;
        return r;
    endfunction

    function automatic void predict_insert(logic [63:0] value, logic [5:0] node);
        int pos;
        if (ring_cnt >= RING_SIZE)
        begin
            queue_result(make_res(KIND_ACK, 6'd0, 3'd0, 1'b0, 64'd0, 1'b1, 1'b1));
            return;
        end
        pos = lower_index(value);
        while (pos < ring_cnt && ring_val[pos] == value)
        begin
            value = value + 64'd1;
            pos = lower_index(value);
        end
        for (int i = ring_cnt; i > pos; i--)
        begin
            ring_val[i] = ring_val[i-1];
            ring_own[i] = ring_own[i-1];
        end
        ring_val[pos] = value;
        ring_own[pos] = node;
        ring_cnt++;
        queue_result(make_res(KIND_ACK, 6'd0, 3'd0, 1'b0, value, 1'b0, 1'b1));
    endfunction

    function automatic void predict_replicas(logic [63:0] h);
        int start, idx, n, want;
        logic [63:0] taken;
        if (ring_cnt == 0)
        begin
            queue_result(make_res(KIND_REPLICA, 6'd0, 3'd0, 1'b0, 64'd0, 1'b0, 1'b1));
            return;
        end
        want = (repl_factor == 0) ? 1 : int'(repl_factor);
        if (want > WANT_MAX)
            want = WANT_MAX;
        start = lower_index(h);
        if (start >= ring_cnt)
            start = 0;
        idx = start;
        n = 0;
        taken = '0;
        do
        begin
            if (!taken[ring_own[idx]])
            begin
                taken[ring_own[idx]] = 1'b1;
                queue_result(make_res(KIND_REPLICA, ring_own[idx], n[2:0], 1'b1,
                                      64'd0, 1'b0, 1'b0));
                n++;
            end
            if (n >= want)
                break;
            idx = (idx + 1 >= ring_cnt) ? 0 : idx + 1;
        end
        while (idx != start);
        expected_results[expected_results.size() - 1].last = 1'b1;
    endfunction

    function automatic void predict_word(logic [1:0] mode, logic [7:0] kbyte, logic klast,
                                         logic [63:0] value, logic [5:0] node);
        logic [63:0] h;
        case (mode)
            MODE_KEY:
            begin
                hash_acc = (hash_acc ^ {56'd0, kbyte}) * 64'd1099511628211;
                if (klast)
                begin
                    h = hash_acc;
                    hash_acc = FNV_BASIS;
                    predict_replicas(h);
                end
            end
            MODE_INSERT: predict_insert(value, node);
            MODE_CLEAR:  ring_cnt = 0;
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Called at a rising edge; returns at the edge where the word was taken.
    task automatic send_word(logic [1:0] mode, logic [7:0] kbyte, logic klast,
                             logic [63:0] value, logic [5:0] node);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tlast  <= klast;
        s_tdata  <= {2'b00, node, value, kbyte};
        do @(posedge clk); while (!s_tready);
        predict_word(mode, kbyte, klast, value, node);
    endtask

    task automatic send_key(int nbytes);
        for (int i = 0; i < nbytes; i++)
            send_word(MODE_KEY, 8'($urandom_range(0, 255)), i == nbytes - 1,
                      {$urandom, $urandom}, 6'($urandom_range(0, 63)));
    endtask

    task automatic send_insert(logic [63:0] value, logic [5:0] node);
        send_word(MODE_INSERT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  value, node);
    endtask

    // The register only changes once the block has drained and gone quiet.
    task automatic write_factor(logic [3:0] v);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid   <= 1'b0;
        repl_factor  = v;
    endtask

    task automatic test_empty_ring();
        send_word(MODE_KEY, 8'h00, 1'b0, 64'd0, 6'd0);
        send_word(MODE_KEY, 8'hFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63);
        send_word(MODE_RESERVED, 8'hA5, 1'b1, 64'h1234, 6'd5);
        send_word(MODE_CLEAR, 8'h5A, 1'b0, 64'd7, 6'd1);
        send_key(1);
    endtask

    task automatic test_insert_edges();
        send_insert(64'hFFFF_FFFF_FFFF_FFFF, 6'd63);
        // A second copy of the top value wraps to zero, a third lands on one.
        send_insert(64'hFFFF_FFFF_FFFF_FFFF, 6'd1);
        send_insert(64'hFFFF_FFFF_FFFF_FFFF, 6'd2);
        send_insert(64'd0, 6'd0);
        // Inserts may sit between the bytes of a key without touching its hash.
        send_word(MODE_KEY, 8'h31, 1'b0, 64'd0, 6'd0);
        send_insert(64'h8000_0000_0000_0000, 6'd63);
        send_word(MODE_KEY, 8'h32, 1'b1, 64'd0, 6'd0);
        send_key(3);
    endtask

    task automatic test_wide_lookup();
        write_factor(4'd8);
        send_key(2);
        send_insert(64'h4000_0000_0000_0000, 6'd2);
        send_key(4);
        write_factor(4'd15);
        send_key(1);
        write_factor(4'd0);
        send_key(2);
    endtask

    task automatic test_refill();
        write_factor(4'd3);
        no_idle = 1'b1;
        send_word(MODE_CLEAR, 8'd0, 1'b0, 64'd0, 6'd0);
        // Ascending values append at the top, so no entry has to move.
        for (int i = 0; i < REFILL_COUNT; i++)
            send_insert({i[9:0], 54'd0} | 64'(i), i[5:0]);
        no_idle = 1'b0;
        send_insert(64'd12345, 6'd9);
        send_key(3);
        send_word(MODE_CLEAR, 8'd0, 1'b0, 64'd0, 6'd0);
        send_key(2);
    endtask

    task automatic random_phase(int words);
        int sent, r, n;
        logic [63:0] v;
        sent = 0;
        while (sent < words)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                n = $urandom_range(1, 6);
                send_key(n);
                sent += n;
            end
            else if (r < 85)
            begin
                // Some inserts reuse a ring value to force collision bumping.
                if (ring_cnt > 0 && $urandom_range(0, 3) == 0)
                    v = ring_val[$urandom_range(0, ring_cnt - 1)];
                else
                    v = {$urandom, $urandom};
                send_insert(v, 6'($urandom_range(0, 63)));
                sent++;
            end
            else if (r < 90)
            begin
                send_word(MODE_CLEAR, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), {$urandom, $urandom},
                          6'($urandom_range(0, 63)));
                sent++;
            end
            else if (r < 93)
            begin
                send_word(MODE_RESERVED, 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), {$urandom, $urandom},
                          6'($urandom_range(0, 63)));
            end
            else
            begin
                send_word(MODE_KEY, 8'($urandom_range(0, 255)), 1'b0, 64'd0, 6'd0);
                sent++;
            end
        end
    endtask

    task automatic test_random();
        logic [3:0] settings[5] = '{4'd1, 4'd8, 4'd2, 4'd5, 4'd4};
        foreach (settings[i])
        begin
            write_factor(settings[i]);
            random_phase(PHASE_WORDS);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        s_tlast     = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        errors      = 0;
        idle_cycles = 0;
        no_idle     = 1'b0;
        ring_cnt    = 0;
        hash_acc    = FNV_BASIS;
        repl_factor = 4'd1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_ring();
        test_insert_edges();
        test_wide_lookup();
        test_refill();
        test_random();

        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
